[rtl/core/rc4_pkg.sv]
// Shared types and constants for the RC4 keystream generator.
// No dependencies.
package rc4_pkg;

   localparam logic       OP_LOAD     = 1'b0;
   localparam logic       OP_GEN      = 1'b1;
   localparam int         ADDR_W      = 8;
   localparam int         DATA_W      = 8;
   localparam int         COUNT_W     = 9;
   localparam logic [8:0] KEY_LEN_MAX = 9'd256;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DATA_W-1:0] byte_type;

   // sequencer status toward the top level
   typedef struct packed {
      logic     ready;
      logic     push;
      byte_type data;
   } seq_stat_type;

endpackage

[rtl/core/rc4_keystream_generator.sv]
// Top level of the RC4 keystream generator: request handshake, result
// register and the sequencer. Depends on rc4_pkg and rc4_seq.
//
// Usage:
//  - req channel: one beat per item. req_operation = 0 loads req_key_byte
//    into the key store; with req_key_last set it also runs the key
//    schedule. req_operation = 1 asks for one keystream byte.
//  - rsp channel: one beat per generate item, carrying rsp_keystream_byte.
//    Load items give no rsp beat.
//  - A last key byte runs an identity sweep of the permutation RAM and
//    then 256 schedule steps, all through the one permutation RAM.
//  - A generate item runs the accept, then three RAM read/swap steps;
//    its byte goes into the result register from the last step, and the
//    next item can be taken once the sequencer is back in idle.
//  - Key bytes beyond 256 are dropped.
//  - Reset: synchronous. After reset the permutation RAM is swept to the
//    identity with req_ready low.
//  - Stall: if rsp is held off, the result register keeps its byte while
//    the next item runs; a further byte waits in its last step.
module rc4_keystream_generator
   import rc4_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_operation,
   input  byte_type req_key_byte,
   input  logic     req_key_last,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output byte_type rsp_keystream_byte
);

   seq_stat_type stat;
   logic         accept;
   logic         rsp_room;
   logic         rsp_valid_ff, rsp_valid_in;
   byte_type     rsp_data_ff, rsp_data_in;

   assign req_ready = stat.ready;
   assign accept    = req_valid & stat.ready;
   // result register can take a byte when empty or draining this cycle
   assign rsp_room  = ~rsp_valid_ff | rsp_ready;

   rc4_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .key_byte  (req_key_byte),
      .key_last  (req_key_last),
      .rsp_room  (rsp_room),
      .stat      (stat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (stat.push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = stat.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keystream_byte = rsp_data_ff;

   // a byte is only pushed when the result register has room
   assert property (@(posedge clock) disable iff (reset)
      stat.push |-> rsp_room)
      else $error("result pushed into a full register");

   // sequencer never pushes while it is taking requests
   assert property (@(posedge clock) disable iff (reset)
      stat.ready |-> !stat.push)
      else $error("push while idle");

   // a last key byte starts the schedule, so the block goes busy
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_LOAD && req_key_last) |=> !req_ready)
      else $error("key schedule did not start");

   // a generate beat cannot produce a byte in the very next cycle
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_GEN) |=> !stat.push)
      else $error("keystream byte too early");

endmodule

[rtl/core/rc4_ram.sv]
// 256 x 8 single-write, single-read memory with registered read data.
// Depends on rc4_pkg.
module rc4_ram
   import rc4_pkg::*;
(
   input  logic     clock,
   input  logic     we,
   input  addr_type waddr,
   input  byte_type wdata,
   input  addr_type raddr,
   output byte_type rdata
);

   byte_type mem [0:255];
   byte_type rdata_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/rc4_seq.sv]
// Sequencer for the RC4 core: identity sweep, key schedule and keystream
// steps around one shared 8-bit adder. Depends on rc4_pkg and rc4_ram.
module rc4_seq
   import rc4_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         operation,
   input  byte_type     key_byte,
   input  logic         key_last,
   input  logic         rsp_room,
   output seq_stat_type stat
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_INIT = 4'd1;
   localparam logic [3:0] ST_KRD  = 4'd2;
   localparam logic [3:0] ST_KADD = 4'd3;
   localparam logic [3:0] ST_KSW1 = 4'd4;
   localparam logic [3:0] ST_KSW2 = 4'd5;
   localparam logic [3:0] ST_G1   = 4'd6;
   localparam logic [3:0] ST_G2   = 4'd7;
   localparam logic [3:0] ST_G3   = 4'd8;

   logic [3:0]         state_ff, state_in;
   addr_type           n_ff, n_in;
   addr_type           kp_ff, kp_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   addr_type           i_ff, i_in;
   addr_type           j_ff, j_in;
   byte_type           si_ff, si_in;
   byte_type           sj_ff, sj_in;
   addr_type           t_ff, t_in;
   logic               pending_ff, pending_in;

   // shared adder
   byte_type add_a, add_b, add_c, sum;

   logic     p_we, k_we;
   addr_type p_waddr, p_raddr, k_waddr, k_raddr;
   byte_type p_wdata, p_rdata, k_rdata;
   logic [COUNT_W-1:0] kp_next;

   rc4_ram u_perm (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   rc4_ram u_key (
      .clock (clock),
      .we    (k_we),
      .waddr (k_waddr),
      .wdata (key_byte),
      .raddr (k_raddr),
      .rdata (k_rdata)
   );

   assign sum     = add_a + add_b + add_c;
   assign kp_next = {1'b0, kp_ff} + 9'd1;

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      kp_in      = kp_ff;
      count_in   = count_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      si_in      = si_ff;
      sj_in      = sj_ff;
      t_in       = t_ff;
      pending_in = pending_ff;
      add_a      = '0;
      add_b      = '0;
      add_c      = '0;
      p_we       = 1'b0;
      p_waddr    = n_ff;
      p_wdata    = n_ff;
      p_raddr    = n_ff;
      k_we       = 1'b0;
      k_waddr    = count_ff[ADDR_W-1:0];
      k_raddr    = kp_ff;
      stat.ready = 1'b0;
      stat.push  = 1'b0;
      stat.data  = p_rdata;

      unique case (state_ff)
         ST_IDLE: begin
            stat.ready = 1'b1;
            add_a      = i_ff;
            add_b      = 8'd1;
            p_raddr    = sum;
            if (accept) begin
               if (operation == OP_GEN) begin
                  i_in     = sum;
                  state_in = ST_G1;
               end else begin
                  if (count_ff < KEY_LEN_MAX) begin
                     k_we     = 1'b1;
                     count_in = count_ff + 9'd1;
                  end
                  if (key_last) begin
                     n_in       = '0;
                     pending_in = 1'b1;
                     state_in   = ST_INIT;
                  end
               end
            end
         end
         ST_INIT: begin
            p_we = 1'b1;
            n_in = n_ff + 8'd1;
            if (n_ff == 8'hff) begin
               pending_in = 1'b0;
               j_in       = '0;
               kp_in      = '0;
               state_in   = pending_ff ? ST_KRD : ST_IDLE;
            end
         end
         ST_KRD: begin
            state_in = ST_KADD;
         end
         ST_KADD: begin
            add_a    = j_ff;
            add_b    = p_rdata;
            add_c    = k_rdata;
            j_in     = sum;
            p_raddr  = sum;
            si_in    = p_rdata;
            state_in = ST_KSW1;
         end
         ST_KSW1: begin
            p_we     = 1'b1;
            p_wdata  = p_rdata;
            state_in = ST_KSW2;
         end
         ST_KSW2: begin
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = si_ff;
            kp_in   = (kp_next >= count_ff) ? '0 : kp_next[ADDR_W-1:0];
            n_in    = n_ff + 8'd1;
            if (n_ff == 8'hff) begin
               i_in     = '0;
               j_in     = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KRD;
            end
         end
         ST_G1: begin
            add_a    = j_ff;
            add_b    = p_rdata;
            j_in     = sum;
            p_raddr  = sum;
            si_in    = p_rdata;
            state_in = ST_G2;
         end
         ST_G2: begin
            p_we     = 1'b1;
            p_waddr  = i_ff;
            p_wdata  = p_rdata;
            add_a    = si_ff;
            add_b    = p_rdata;
            p_raddr  = sum;
            t_in     = sum;
            sj_in    = p_rdata;
            state_in = ST_G3;
         end
         ST_G3: begin
            // read of S[t] predates the swap; patch the two swapped slots
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = si_ff;
            p_raddr = t_ff;
            if (t_ff == i_ff) begin
               stat.data = sj_ff;
            end else if (t_ff == j_ff) begin
               stat.data = si_ff;
            end
            if (rsp_room) begin
               stat.push = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         n_ff       <= '0;
         kp_ff      <= '0;
         count_ff   <= '0;
         i_ff       <= '0;
         j_ff       <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         n_ff       <= n_in;
         kp_ff      <= kp_in;
         count_ff   <= count_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         pending_ff <= pending_in;
      end
      si_ff <= si_in;
      sj_ff <= sj_in;
      t_ff  <= t_in;
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rc4_keystream_generator: random and directed key loads and
// keystream requests, checked against an in-bench ARCFOUR predictor. Depends on rc4_pkg.
module tb_top;
   import rc4_pkg::*;

   // Cycles with no beat on either channel before the run is declared hung.
   // The longest quiet stretch is a key schedule plus a long gap.
   localparam int IDLE_LIMIT   = 6000;
   // Settle time after the last expected byte; covers a trailing key schedule.
   localparam int DRAIN_CYCLES = 1400;
   localparam int ITEM_TARGET  = 1750;

   //------------------------------------------------------------------------
   // Predictor and store of expected keystream bytes
   //------------------------------------------------------------------------
   class keystream_scoreboard;
      byte_type               perm[256];
      byte_type               key_mem[256];
      logic [COUNT_W-1:0]     key_len;
      addr_type               idx_i;
      addr_type               idx_j;
      byte_type               pending_bytes[$];
      int unsigned            mismatches;

      function new();
         for (int n = 0; n < 256; n++) begin
            perm[n]    = byte_type'(n);
            key_mem[n] = '0;
         end
         key_len     = '0;
         idx_i       = '0;
         idx_j       = '0;
         mismatches  = 0;
      endfunction

      function void run_key_schedule();
         int       len;
         addr_type j;
         byte_type t;
         len = (key_len == 0) ? 1 : int'(key_len);
         for (int n = 0; n < 256; n++) perm[n] = byte_type'(n);
         j = '0;
         for (int n = 0; n < 256; n++) begin
            j          = j + perm[n] + key_mem[(n % len) & 255];
            t          = perm[n];
            perm[n]    = perm[j];
            perm[j]    = t;
         end
         idx_i = '0;
         idx_j = '0;
      endfunction

      // Called for every accepted req beat.
      function void note_beat(logic op, byte_type kb, logic last);
         byte_type t;
         addr_type sum;
         if (op == OP_LOAD) begin
            // bytes past the maximum key length are dropped
            if (key_len < KEY_LEN_MAX) begin
               key_mem[key_len[ADDR_W-1:0]] = kb;
               key_len                      = key_len + 1'b1;
            end
            if (last) begin
               run_key_schedule();
               key_len = '0;
            end
         end else begin
            idx_i       = idx_i + 1'b1;
            idx_j       = idx_j + perm[idx_i];
            t           = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            sum         = perm[idx_i] + perm[idx_j];
            pending_bytes.push_back(perm[sum]);
         end
      endfunction

      // Called for every accepted rsp beat.
      function void check_beat(byte_type got);
         byte_type want;
         if (pending_bytes.size() == 0) begin
            $display("%0t rsp beat with nothing expected: got %02h", $time, got);
            mismatches++;
         end else begin
            want = pending_bytes.pop_front();
            if (got !== want) begin
               $display("%0t keystream_byte mismatch: expected %02h, actual %02h",
                        $time, want, got);
               mismatches++;
            end
         end
      endfunction
   endclass

   //------------------------------------------------------------------------
   // DUT and clock
   //------------------------------------------------------------------------
   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   logic     req_operation;
   byte_type req_key_byte;
   logic     req_key_last;
   logic     rsp_valid;
   logic     rsp_ready;
   byte_type rsp_keystream_byte;

   rc4_keystream_generator u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_key_byte       (req_key_byte),
      .req_key_last       (req_key_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_keystream_byte (rsp_keystream_byte)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   keystream_scoreboard sb;
   bit                  calm;        // when set, neither side idles
   int unsigned         items_sent;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   //------------------------------------------------------------------------
   // req side: one beat per call. Valid stays up across back-to-back beats,
   // so it is only lowered when a gap follows.
   //------------------------------------------------------------------------
   task automatic send_item(logic op, byte_type kb, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key_byte  <= kb;
      req_key_last  <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_beat(op, kb, last);
      items_sent++;
   endtask

   // Key of len bytes, all fixed_val or random when fixed_val < 0.
   // Only the final beat carries the last mark.
   task automatic send_key(int len, int fixed_val);
      byte_type kb;
      for (int k = 0; k < len; k++) begin
         kb = (fixed_val < 0) ? byte_type'($urandom) : byte_type'(fixed_val);
         send_item(OP_LOAD, kb, k == len - 1);
      end
   endtask

   // Generate beats with junk in the load fields, which the block must ignore.
   task automatic gen_bytes(int count);
      for (int k = 0; k < count; k++)
         send_item(OP_GEN, byte_type'($urandom), 1'($urandom_range(0, 1)));
   endtask

   // Random mix of loads and generates, last mark set now and then.
   task automatic send_noise(int count);
      logic op;
      for (int k = 0; k < count; k++) begin
         op = 1'($urandom_range(0, 1));
         send_item(op, byte_type'($urandom), ($urandom_range(0, 7) == 0));
      end
   endtask

   //------------------------------------------------------------------------
   // rsp side: random back-pressure, check every accepted beat
   //------------------------------------------------------------------------
   initial begin : rsp_side
      int hold;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_beat(rsp_keystream_byte);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   //------------------------------------------------------------------------
   // Watchdog: quiet cycles on both channels
   //------------------------------------------------------------------------
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   //------------------------------------------------------------------------
   // Stimulus
   //------------------------------------------------------------------------
   initial begin : stimulus
      int seq;
      int r;
      sb            = new();
      calm          = 1'b0;
      items_sent    = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_LOAD;
      req_key_byte  <= '0;
      req_key_last  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      gen_bytes(3);                 // no key yet: identity permutation
      send_key(1, 0);               // single all-zero key byte
      gen_bytes(3);
      send_key(1, 255);             // single all-ones key byte
      gen_bytes(3);
      send_key(3, -1);
      gen_bytes(3);
      // generate beat in the middle of a key load
      send_item(OP_LOAD, byte_type'($urandom), 1'b0);
      send_item(OP_GEN, byte_type'($urandom), 1'b1);
      send_item(OP_LOAD, byte_type'($urandom), 1'b1);
      gen_bytes(2);

      // Random part: mostly well-formed key-then-keystream sequences.
      seq = 0;
      while (items_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 9) == 0);
         r    = $urandom_range(0, 99);
         if (seq == 4 || r < 2) begin
            // full-length and over-length keys; extra bytes are dropped
            send_key($urandom_range(256, 259), -1);
            gen_bytes($urandom_range(4, 20));
         end else if (r < 87) begin
            if ($urandom_range(0, 99) < 80) send_key($urandom_range(1, 16), -1);
            else send_key($urandom_range(17, 64), -1);
            gen_bytes($urandom_range(1, 40));
         end else begin
            send_noise($urandom_range(1, 8));
         end
         seq++;
      end
      req_valid <= 1'b0;
      calm      = 1'b0;

      // Drain, then let any trailing key schedule finish.
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/rc4_pkg.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_seq.sv
rtl/core/rc4_keystream_generator.sv
tb/tb_top.sv
